/* rtl/dual_counter_nand_branch_predictor_top_assert.svh */
// Assertion macros shared by the checker of the dual-counter branch predictor.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef DUAL_COUNTER_NAND_BRANCH_PREDICTOR_TOP_ASSERT_SVH
`define DUAL_COUNTER_NAND_BRANCH_PREDICTOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DCNBP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DCNBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dcnbp_pkg.sv */
// Package of the dual-counter branch predictor: sizes, opcodes, row layout
// and saturating counter helpers. It depends on nothing else.
`default_nettype none

package dcnbp_pkg;

  localparam int unsigned TableEntries = 2048;
  localparam int unsigned IdxBits      = $clog2(TableEntries);
  localparam int unsigned RowBits      = IdxBits - 1;
  localparam int unsigned CtrBits      = 2;
  localparam int unsigned Threads      = 4;
  localparam int unsigned ThreadBits   = 2;
  localparam int unsigned AddrShift    = 2;
  localparam int unsigned AddrBits     = 48;
  localparam int unsigned OpBits       = 3;

  typedef enum logic [OpBits-1:0] {
    OpLookup    = 3'd0,
    OpUncond    = 3'd1,
    OpBtbUpdate = 3'd2,
    OpSquash    = 3'd3,
    OpUpdate    = 3'd4
  } op_e;

  typedef logic [CtrBits-1:0] ctr_t;
  typedef logic [IdxBits-1:0] hist_t;
  typedef logic [RowBits-1:0] row_addr_t;

  // One memory row holds the two neighboring entries of both tables.
  typedef struct packed {
    ctr_t [1:0] tk;
    ctr_t [1:0] nt;
  } row_t;

  localparam ctr_t CtrMax = '1;

  function automatic ctr_t ctr_inc(ctr_t c);
    return (c == CtrMax) ? c : c + ctr_t'(1);
  endfunction

  function automatic ctr_t ctr_dec(ctr_t c);
    return (c == '0) ? c : c - ctr_t'(1);
  endfunction

  function automatic logic ctr_top(ctr_t c);
    return c[CtrBits-1];
  endfunction

endpackage

`default_nettype wire

/* rtl/dual_counter_nand_branch_predictor_top.sv */
// Pipeline: an accepted beat is registered into stage one, then into the result registers.
// Throughput: one beat per cycle for any mix of opcodes, threads and addresses while the result port is not stalled.
// Reset: histories clear at once; a clearing pass then zeroes the 1024 rows of
// the counter memory, one row a cycle, while stall_o stays high.
// Uses dcnbp_pkg; counter rows live in a memory with one write port and one registered read port.
`default_nettype none

module dual_counter_nand_branch_predictor_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                valid_i,
  output logic                                     stall_o,
  input  wire logic [dcnbp_pkg::OpBits-1:0]        opcode_i,
  input  wire logic [dcnbp_pkg::ThreadBits-1:0]    thread_i,
  input  wire logic [dcnbp_pkg::AddrBits-1:0]      branch_addr_i,
  input  wire logic                                taken_i,
  input  wire logic                                squashed_i,
  input  wire logic [dcnbp_pkg::IdxBits-1:0]       saved_history_i,
  input  wire logic                                saved_taken_pred_i,
  input  wire logic                                saved_final_pred_i,
  output logic                                     valid_o,
  input  wire logic                                stall_i,
  output logic                                     final_pred_o,
  output logic                                     taken_pred_o,
  output logic                                     not_taken_pred_o,
  output logic [dcnbp_pkg::IdxBits-1:0]            history_snapshot_o
);

  logic                   accept;
  logic                   s1_adv;

  logic                   clr_busy_q;
  dcnbp_pkg::row_addr_t   clr_cnt_q;

  dcnbp_pkg::hist_t       hist_q [dcnbp_pkg::Threads];
  dcnbp_pkg::row_t        mem [dcnbp_pkg::TableEntries/2];
  dcnbp_pkg::row_t        mem_rd_q;

  logic                   s1_v_q;
  dcnbp_pkg::op_e         s1_op_q;
  logic [dcnbp_pkg::ThreadBits-1:0] s1_thread_q;
  logic                   s1_taken_q;
  logic                   s1_squashed_q;
  dcnbp_pkg::hist_t       s1_saved_q;
  logic                   s1_stp_q;
  logic                   s1_sfp_q;
  dcnbp_pkg::hist_t       s1_hist_q;
  dcnbp_pkg::hist_t       s1_idx_q;
  logic                   s1_fwd_q;
  dcnbp_pkg::row_t        s1_fwd_row_q;

  logic                   out_v_q;
  logic                   out_fp_q;
  logic                   out_tp_q;
  logic                   out_ntp_q;
  dcnbp_pkg::hist_t       out_snap_q;

  dcnbp_pkg::row_t        row_eff;
  dcnbp_pkg::row_t        new_row;
  logic                   sel;
  dcnbp_pkg::ctr_t        tk_c;
  dcnbp_pkg::ctr_t        nt_c;
  logic                   tp;
  logic                   ntp;
  logic                   fp;
  logic                   res_fp;
  logic                   res_tp;
  logic                   res_ntp;
  dcnbp_pkg::hist_t       res_snap;
  logic                   hist_we;
  dcnbp_pkg::hist_t       hist_new;
  logic                   mem_we;

  dcnbp_pkg::hist_t       hist_fwd;
  dcnbp_pkg::hist_t       ash;
  dcnbp_pkg::hist_t       idx_in;
  dcnbp_pkg::row_addr_t   rd_row;
  logic                   mem_wr_en;
  dcnbp_pkg::row_addr_t   wr_addr;
  dcnbp_pkg::row_t        wr_data;
  logic                   fwd_hit;

  assign s1_adv  = s1_v_q & (~out_v_q | ~stall_i);
  assign stall_o = clr_busy_q | (s1_v_q & ~s1_adv);
  assign accept  = valid_i & ~stall_o;

  // Stage one: pick the counters, form the result and the state updates.
  always_comb begin
    row_eff  = s1_fwd_q ? s1_fwd_row_q : mem_rd_q;
    sel      = s1_idx_q[0];
    tk_c     = row_eff.tk[sel];
    nt_c     = row_eff.nt[sel];
    tp       = dcnbp_pkg::ctr_top(tk_c);
    ntp      = dcnbp_pkg::ctr_top(nt_c);
    fp       = tp & ~ntp;
    res_fp   = 1'b0;
    res_tp   = 1'b0;
    res_ntp  = 1'b0;
    res_snap = '0;
    hist_we  = 1'b0;
    hist_new = s1_hist_q;
    mem_we   = 1'b0;
    new_row  = row_eff;
    unique case (s1_op_q)
      dcnbp_pkg::OpLookup: begin
        res_fp   = fp;
        res_tp   = tp;
        res_ntp  = ntp;
        res_snap = s1_hist_q;
        hist_we  = 1'b1;
        hist_new = {s1_hist_q[dcnbp_pkg::IdxBits-2:0], fp};
      end
      dcnbp_pkg::OpUncond: begin
        res_fp   = 1'b1;
        res_tp   = 1'b1;
        res_ntp  = 1'b1;
        res_snap = s1_hist_q;
        hist_we  = 1'b1;
        hist_new = {s1_hist_q[dcnbp_pkg::IdxBits-2:0], 1'b1};
      end
      dcnbp_pkg::OpBtbUpdate: begin
        hist_we  = 1'b1;
        hist_new = {s1_hist_q[dcnbp_pkg::IdxBits-1:1], 1'b0};
      end
      dcnbp_pkg::OpSquash: begin
        hist_we  = 1'b1;
        hist_new = s1_saved_q;
      end
      dcnbp_pkg::OpUpdate: begin
        if (s1_squashed_q) begin
          hist_we  = 1'b1;
          hist_new = {s1_saved_q[dcnbp_pkg::IdxBits-2:0], s1_taken_q};
        end else begin
          mem_we = 1'b1;
          if (s1_sfp_q == s1_taken_q) begin
            if (s1_stp_q) begin
              new_row.tk[sel] = s1_taken_q ? dcnbp_pkg::ctr_inc(tk_c)
                                           : dcnbp_pkg::ctr_dec(tk_c);
            end else begin
              new_row.nt[sel] = s1_taken_q ? dcnbp_pkg::ctr_inc(nt_c)
                                           : dcnbp_pkg::ctr_dec(nt_c);
            end
          end else if (s1_taken_q) begin
            new_row.nt[sel] = dcnbp_pkg::ctr_inc(nt_c);
          end else begin
            new_row.tk[sel] = dcnbp_pkg::ctr_dec(tk_c);
          end
        end
      end
      default: begin
        hist_we = 1'b0;
      end
    endcase
  end

  // Input side: history with the leaving beat forwarded, then the row address.
  always_comb begin
    if (s1_adv && hist_we && (s1_thread_q == thread_i)) begin
      hist_fwd = hist_new;
    end else begin
      hist_fwd = hist_q[thread_i];
    end
    ash = branch_addr_i[dcnbp_pkg::AddrShift +: dcnbp_pkg::IdxBits];
    if (opcode_i == dcnbp_pkg::OpUpdate) begin
      idx_in = ~(ash & saved_history_i);
    end else begin
      idx_in = ~(ash & hist_fwd);
    end
    rd_row    = idx_in[dcnbp_pkg::IdxBits-1:1];
    mem_wr_en = clr_busy_q | (s1_adv & mem_we);
    wr_addr   = clr_busy_q ? clr_cnt_q : s1_idx_q[dcnbp_pkg::IdxBits-1:1];
    wr_data   = clr_busy_q ? '0 : new_row;
    fwd_hit   = s1_adv & mem_we & (s1_idx_q[dcnbp_pkg::IdxBits-1:1] == rd_row);
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      mem_rd_q <= mem[rd_row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + dcnbp_pkg::row_addr_t'(1);
      if (clr_cnt_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '{default: '0};
    end else if (s1_adv && hist_we) begin
      hist_q[s1_thread_q] <= hist_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        out_v_q <= 1'b1;
      end else if (!stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q       <= dcnbp_pkg::op_e'(opcode_i);
      s1_thread_q   <= thread_i;
      s1_taken_q    <= taken_i;
      s1_squashed_q <= squashed_i;
      s1_saved_q    <= saved_history_i;
      s1_stp_q      <= saved_taken_pred_i;
      s1_sfp_q      <= saved_final_pred_i;
      s1_hist_q     <= hist_fwd;
      s1_idx_q      <= idx_in;
      s1_fwd_q      <= fwd_hit;
      s1_fwd_row_q  <= new_row;
    end
    if (s1_adv) begin
      out_fp_q   <= res_fp;
      out_tp_q   <= res_tp;
      out_ntp_q  <= res_ntp;
      out_snap_q <= res_snap;
    end
  end

  assign valid_o            = out_v_q;
  assign final_pred_o       = out_fp_q;
  assign taken_pred_o       = out_tp_q;
  assign not_taken_pred_o   = out_ntp_q;
  assign history_snapshot_o = out_snap_q;

endmodule

`default_nettype wire

/* rtl/dcnbp_checker.sv */
// Port-level checker for the dual-counter branch predictor and its bind.
// Uses dcnbp_pkg and the macros of dual_counter_nand_branch_predictor_top_assert.svh.
`default_nettype none
`include "dual_counter_nand_branch_predictor_top_assert.svh"

module dcnbp_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             valid_i,
  input wire logic                             stall_o,
  input wire logic                             valid_o,
  input wire logic                             stall_i,
  input wire logic                             final_pred_o,
  input wire logic                             taken_pred_o,
  input wire logic                             not_taken_pred_o,
  input wire logic [dcnbp_pkg::IdxBits-1:0]    history_snapshot_o
);

  `DCNBP_ASSERT_NEXT(a_out_hold, valid_o && stall_i, valid_o, "Result beat dropped while stalled.")
  `DCNBP_ASSERT_NEXT(a_out_stable, valid_o && stall_i, $stable(final_pred_o) && $stable(taken_pred_o) && $stable(not_taken_pred_o) && $stable(history_snapshot_o), "Stalled result beat changed.")
  `DCNBP_ASSERT_SAME(a_rise_after_accept, $rose(valid_o), $past(valid_i && !stall_o, 2), "Result beat without an input beat two cycles earlier.")
  `DCNBP_ASSERT_SAME(a_final_needs_taken, valid_o && final_pred_o, taken_pred_o, "Final prediction taken without the taken counter.")

endmodule

bind dual_counter_nand_branch_predictor_top dcnbp_checker u_dcnbp_checker (.*);

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the dual-counter branch predictor top level.
// Drives directed and random beats through the valid/stall ports and checks each result against
// fixed expected values or a local model of the histories and counter tables. Depends on dcnbp_pkg.
`timescale 1ns / 100ps

module tb;
  import dcnbp_pkg::*;

  localparam logic [OpBits-1:0] OpSpare5 = 3'd5;
  localparam logic [OpBits-1:0] OpSpare6 = 3'd6;
  localparam logic [OpBits-1:0] OpSpare7 = 3'd7;
  localparam int unsigned RandItems = 1100;
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned QuietCycles = 400;
  localparam int unsigned IdlePct = 21;

  typedef struct packed {
    logic [OpBits-1:0]     opcode;
    logic [ThreadBits-1:0] thread;
    logic [AddrBits-1:0]   addr;
    logic                  taken;
    logic                  squashed;
    hist_t                 saved_history;
    logic                  saved_taken_pred;
    logic                  saved_final_pred;
  } br_beat_t;

  typedef struct packed {
    logic  final_pred;
    logic  taken_pred;
    logic  not_taken_pred;
    hist_t history_snapshot;
  } br_result_t;

  typedef struct {
    br_beat_t   beat;
    logic       typed;
    br_result_t res;
  } dir_row_t;

  typedef struct {
    logic [ThreadBits-1:0] thread;
    logic [AddrBits-1:0]   addr;
    hist_t                 snapshot;
    logic                  taken_pred;
    logic                  final_pred;
  } inflight_br_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  valid_i;
  logic                  stall_o;
  logic [OpBits-1:0]     opcode_i;
  logic [ThreadBits-1:0] thread_i;
  logic [AddrBits-1:0]   branch_addr_i;
  logic                  taken_i;
  logic                  squashed_i;
  hist_t                 saved_history_i;
  logic                  saved_taken_pred_i;
  logic                  saved_final_pred_i;
  logic                  valid_o;
  logic                  stall_i;
  logic                  final_pred_o;
  logic                  taken_pred_o;
  logic                  not_taken_pred_o;
  hist_t                 history_snapshot_o;

  hist_t        ghist [Threads];
  ctr_t         tk_ctr [TableEntries];
  ctr_t         nt_ctr [TableEntries];
  br_result_t   predicted_q [$];
  dir_row_t     dir_rows [$];
  inflight_br_t inflight [$];
  int unsigned  fails;
  int unsigned  cycles;
  bit           hold_req;

  dual_counter_nand_branch_predictor_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (valid_i),
    .stall_o            (stall_o),
    .opcode_i           (opcode_i),
    .thread_i           (thread_i),
    .branch_addr_i      (branch_addr_i),
    .taken_i            (taken_i),
    .squashed_i         (squashed_i),
    .saved_history_i    (saved_history_i),
    .saved_taken_pred_i (saved_taken_pred_i),
    .saved_final_pred_i (saved_final_pred_i),
    .valid_o            (valid_o),
    .stall_i            (stall_i),
    .final_pred_o       (final_pred_o),
    .taken_pred_o       (taken_pred_o),
    .not_taken_pred_o   (not_taken_pred_o),
    .history_snapshot_o (history_snapshot_o)
  );

  function automatic ctr_t ctr_step(ctr_t c, logic up);
    if (up) begin
      return (&c) ? c : c + 1'b1;
    end
    return (c == '0) ? c : c - 1'b1;
  endfunction

  function automatic hist_t table_index(logic [AddrBits-1:0] addr, hist_t h);
    return ~(hist_t'(addr >> AddrShift) & h);
  endfunction

  function automatic br_result_t predict_branch(br_beat_t b);
    br_result_t r;
    hist_t      h;
    hist_t      idx;
    r = '0;
    h = ghist[b.thread];
    case (b.opcode)
      OpLookup: begin
        idx = table_index(b.addr, h);
        r.taken_pred = tk_ctr[idx][CtrBits-1];
        r.not_taken_pred = nt_ctr[idx][CtrBits-1];
        r.final_pred = r.taken_pred & ~r.not_taken_pred;
        r.history_snapshot = h;
        ghist[b.thread] = {h[IdxBits-2:0], r.final_pred};
      end
      OpUncond: begin
        r.final_pred = 1'b1;
        r.taken_pred = 1'b1;
        r.not_taken_pred = 1'b1;
        r.history_snapshot = h;
        ghist[b.thread] = {h[IdxBits-2:0], 1'b1};
      end
      OpBtbUpdate: ghist[b.thread] = {h[IdxBits-1:1], 1'b0};
      OpSquash: ghist[b.thread] = b.saved_history;
      OpUpdate: begin
        if (b.squashed) begin
          ghist[b.thread] = {b.saved_history[IdxBits-2:0], b.taken};
        end else begin
          idx = table_index(b.addr, b.saved_history);
          if (b.saved_final_pred == b.taken) begin
            if (b.saved_taken_pred) tk_ctr[idx] = ctr_step(tk_ctr[idx], b.taken);
            else nt_ctr[idx] = ctr_step(nt_ctr[idx], b.taken);
          end else if (b.taken) begin
            nt_ctr[idx] = ctr_step(nt_ctr[idx], 1'b1);
          end else begin
            tk_ctr[idx] = ctr_step(tk_ctr[idx], 1'b0);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic dir_row(input logic [OpBits-1:0] op, input int unsigned thr,
                         input logic [AddrBits-1:0] addr, input logic tk, input logic sq,
                         input hist_t saved, input logic stp, input logic sfp,
                         input logic typed, input br_result_t res);
    dir_row_t row;
    row.beat = '{op, ThreadBits'(thr), addr, tk, sq, saved, stp, sfp};
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endtask

  task automatic send_beat(input br_beat_t b, input logic typed, input br_result_t typed_res,
                           output br_result_t r);
    valid_i <= 1'b1;
    opcode_i <= b.opcode;
    thread_i <= b.thread;
    branch_addr_i <= b.addr;
    taken_i <= b.taken;
    squashed_i <= b.squashed;
    saved_history_i <= b.saved_history;
    saved_taken_pred_i <= b.saved_taken_pred;
    saved_final_pred_i <= b.saved_final_pred;
    do @(posedge clk_i); while (stall_o !== 1'b0);
    r = predict_branch(b);
    predicted_q.push_back(typed ? typed_res : r);
  endtask

  task automatic idle_gap(input bit quiet);
    int unsigned gap;
    gap = 0;
    if (!quiet) begin
      while ($urandom_range(99) < IdlePct) gap++;
    end
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    valid_i <= 1'b0;
    do @(posedge clk_i); while (predicted_q.size() != 0);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int unsigned hold_left;
    int unsigned quiet_left;
    bit          hold_done;
    hold_left = 0;
    quiet_left = 0;
    hold_done = 0;
    stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_i <= 1'b1;
        if (hold_left == 0) quiet_left = QuietCycles;
      end else if (quiet_left > 0) begin
        quiet_left--;
        stall_i <= 1'b0;
      end else begin
        stall_i <= ($urandom_range(99) < IdlePct);
      end
    end
  end

  initial begin
    br_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && valid_o === 1'b1 && stall_i === 1'b0) begin
        if (predicted_q.size() == 0) begin
          $error("result beat with no prediction pending");
          fails++;
        end else begin
          want = predicted_q.pop_front();
          if (final_pred_o !== want.final_pred) begin
            $error("final_pred: expected %0d, got %0d", want.final_pred, final_pred_o);
            fails++;
          end
          if (taken_pred_o !== want.taken_pred) begin
            $error("taken_pred: expected %0d, got %0d", want.taken_pred, taken_pred_o);
            fails++;
          end
          if (not_taken_pred_o !== want.not_taken_pred) begin
            $error("not_taken_pred: expected %0d, got %0d", want.not_taken_pred,
                   not_taken_pred_o);
            fails++;
          end
          if (history_snapshot_o !== want.history_snapshot) begin
            $error("history_snapshot: expected %0d, got %0d", want.history_snapshot,
                   history_snapshot_o);
            fails++;
          end
        end
      end
    end
  end

  initial begin
    br_beat_t       b;
    br_result_t     r;
    br_result_t     none;
    inflight_br_t   e;
    logic [AddrBits-1:0] addr_pool [8];
    logic [AddrBits-1:0] amax;
    int unsigned    pick;
    int unsigned    k;
    fails = 0;
    hold_req = 0;
    none = '0;
    amax = '1;
    rst_ni = 1'b0;
    valid_i = 1'b0;
    opcode_i = '0;
    thread_i = '0;
    branch_addr_i = '0;
    taken_i = 1'b0;
    squashed_i = 1'b0;
    saved_history_i = '0;
    saved_taken_pred_i = 1'b0;
    saved_final_pred_i = 1'b0;
    foreach (ghist[i]) ghist[i] = '0;
    foreach (tk_ctr[i]) begin
      tk_ctr[i] = '0;
      nt_ctr[i] = '0;
    end
    addr_pool[0] = '0;
    addr_pool[1] = amax;
    for (int i = 2; i < 8; i++) addr_pool[i] = AddrBits'({$urandom, $urandom});

    // Fresh tables: every counter is zero, so lookups predict not taken.
    dir_row(OpLookup, 0, '0, 0, 0, '0, 0, 0, 1, '{1'b0, 1'b0, 1'b0, 11'd0});
    dir_row(OpUncond, 0, amax, 0, 0, '0, 0, 0, 1, '{1'b1, 1'b1, 1'b1, 11'd0});
    dir_row(OpUncond, 0, amax, 1, 1, '1, 1, 1, 1, '{1'b1, 1'b1, 1'b1, 11'd1});
    dir_row(OpBtbUpdate, 0, '0, 0, 0, '0, 0, 0, 1, none);
    dir_row(OpLookup, 0, amax, 0, 0, '0, 0, 0, 1, '{1'b0, 1'b0, 1'b0, 11'd2});
    dir_row(OpSquash, 0, '0, 0, 0, '1, 0, 0, 1, none);
    dir_row(OpLookup, 0, '0, 0, 0, '0, 0, 0, 1, '{1'b0, 1'b0, 1'b0, 11'd2047});
    dir_row(OpUpdate, 0, amax, 1, 1, '1, 0, 0, 1, none);
    // Train the taken counter of the all-ones index up to saturation.
    for (int i = 0; i < 4; i++) dir_row(OpUpdate, 1, '0, 1, 0, '0, 1, 1, 1, none);
    dir_row(OpLookup, 1, '0, 0, 0, '0, 0, 0, 1, '{1'b1, 1'b1, 1'b0, 11'd0});
    // Taken mispredicts raise the not-taken counter.
    for (int i = 0; i < 2; i++) dir_row(OpUpdate, 2, '0, 1, 0, '0, 0, 0, 1, none);
    dir_row(OpLookup, 2, '0, 0, 0, '0, 0, 0, 1, '{1'b0, 1'b1, 1'b1, 11'd0});
    dir_row(OpUpdate, 3, '0, 0, 0, '0, 0, 0, 0, none);
    // Not-taken mispredicts lower the taken counter down to zero and hold it there.
    for (int i = 0; i < 4; i++) dir_row(OpUpdate, 3, '0, 0, 0, '0, 1, 1, 0, none);
    dir_row(OpLookup, 3, '0, 0, 0, '0, 0, 0, 0, none);
    dir_row(OpSpare5, 3, amax, 1, 1, '1, 1, 1, 1, none);
    dir_row(OpSpare6, 2, amax, 1, 0, '1, 1, 0, 1, none);
    dir_row(OpSpare7, 1, '0, 0, 1, '0, 0, 1, 1, none);
    dir_row(OpLookup, 0, 48'hAAAA_AAAA_AAAA, 0, 0, '0, 0, 0, 0, none);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].res, r);
      idle_gap(0);
    end
    drain_results();

    for (int n = 0; n < RandItems; n++) begin
      if (n == 150) drain_results();
      if (n == 400) hold_req = 1;
      b = '{3'(
        $urandom_range(7)), ThreadBits'($urandom_range(3)), AddrBits'({$urandom, $urandom}),
        1'($urandom), 1'($urandom), hist_t'($urandom), 1'($urandom), 1'($urandom)};
      pick = $urandom_range(99);
      if (pick >= 5) begin
        if ($urandom_range(1) == 0) b.addr = addr_pool[$urandom_range(7)];
        if (pick < 40) begin
          b.opcode = OpLookup;
        end else if (pick < 50) begin
          b.opcode = OpUncond;
        end else if (pick < 55) begin
          b.opcode = OpBtbUpdate;
        end else if (inflight.size() == 0) begin
          b.opcode = OpLookup;
        end else if (pick < 63) begin
          e = inflight[$urandom_range(inflight.size() - 1)];
          b.opcode = OpSquash;
          b.thread = e.thread;
          b.saved_history = e.snapshot;
        end else begin
          k = $urandom_range(inflight.size() - 1);
          e = inflight[k];
          inflight.delete(k);
          b.opcode = OpUpdate;
          b.thread = e.thread;
          b.addr = e.addr;
          b.saved_history = e.snapshot;
          b.saved_taken_pred = e.taken_pred;
          b.saved_final_pred = e.final_pred;
          b.taken = ($urandom_range(99) < 70) ? e.final_pred : ~e.final_pred;
          b.squashed = ($urandom_range(99) < 15);
        end
      end
      send_beat(b, 1'b0, none, r);
      if ((b.opcode == OpLookup || b.opcode == OpUncond) && inflight.size() < 32) begin
        inflight.push_back('{b.thread, b.addr, r.history_snapshot, r.taken_pred,
                             r.final_pred});
      end
      idle_gap(n >= 600 && n < 800);
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
